/* rtl/climbing_robot_gait_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the climbing robot gait sequencer
// Shared concurrent assertion forms, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef CLIMBING_ROBOT_GAIT_SEQUENCER_MACROS_SVH
`define CLIMBING_ROBOT_GAIT_SEQUENCER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CRGS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CRGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/crgs_pkg.sv */
// ----------------------------------------------------------------------------
// Climbing robot gait sequencer package
// Types, codes, constants and helper functions shared by the sequencer files.
// ----------------------------------------------------------------------------
package crgs_pkg;

    localparam int DEF_TICK_WIDTH  = 16;
    localparam int DEF_COUNT_WIDTH = 16;

    // Transaction kinds carried on the input tuser.
    localparam logic [1:0] OP_PASS = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_CMD  = 2'd2;

    localparam logic [1:0] MODE_HOMING = 2'd0;
    localparam logic [1:0] MODE_WALK   = 2'd1;
    localparam logic [1:0] MODE_TURN   = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    // Direction latch: bits 1:0 right driver, bits 3:2 left driver.
    localparam logic [3:0] DIR_NORMAL    = 4'h5;
    localparam logic [3:0] DIR_BRAKE     = 4'hF;
    localparam logic [3:0] DIR_ROT_RIGHT = 4'h6;
    localparam logic [3:0] DIR_ROT_LEFT  = 4'h9;
    localparam logic [1:0] DRV_BRAKE     = 2'h3;

    localparam logic [5:0] PADS_NONE      = 6'h00;
    localparam logic [5:0] PADS_ALL       = 6'h3F;
    localparam logic [5:0] PADS_LEFT_SET  = 6'h15;
    localparam logic [5:0] PADS_RIGHT_SET = 6'h2A;

    localparam logic [8:0]  SERVO_PRESS   = 9'd360;
    localparam logic [8:0]  SERVO_RELEASE = 9'd500;
    localparam logic [12:0] HOMING_PWM    = 13'd1500;
    localparam logic [12:0] TURN_BASE     = 13'd5000;
    localparam logic [12:0] TURN_DROP     = 13'd400;
    localparam logic [7:0]  TURN_STEPS    = 8'd9;
    localparam logic [7:0]  STOP_CMD      = 8'd115;
    localparam logic [7:0]  CMD_OFFSET    = 8'd48;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MOTOR_SPEED  = 3'd0;
    localparam logic [2:0] CFG_TARGET_COUNT = 3'd1;
    localparam logic [2:0] CFG_STEP_LIMIT   = 3'd2;
    localparam logic [2:0] CFG_SETTLE_TICKS = 3'd3;
    localparam logic [2:0] CFG_PRESS_TICKS  = 3'd4;
    localparam logic [2:0] CFG_STEP_TICKS   = 3'd5;
    localparam logic [2:0] CFG_SYNC_BAND    = 3'd6;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int IN_DATA_WIDTH   = 48;
    localparam int OUT_DATA_WIDTH  = 56;

    typedef struct packed {
        logic [12:0] motor_speed;
        logic [15:0] target_count;
        logic [7:0]  step_limit;
        logic [15:0] settle_ticks;
        logic [15:0] press_ticks;
        logic [15:0] step_ticks;
        logic [7:0]  sync_band;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  operation;
        logic        right_sensor;
        logic        left_sensor;
        logic [15:0] right_count;
        logic [15:0] left_count;
        logic [7:0]  command_byte;
    } t_item;

    typedef struct packed {
        logic [12:0] right_pwm;
        logic [12:0] left_pwm;
        logic [1:0]  right_direction;
        logic [1:0]  left_direction;
        logic [5:0]  pad_valves;
        logic        main_valve;
        logic [8:0]  servo_compare;
        logic        clear_right_count;
        logic        clear_left_count;
        logic [1:0]  current_mode;
    } t_result;

    // Truncated 7/10 of a PWM value: times 7 by shift and subtract, then
    // divide by 10 through the reciprocal 52429 / 2^19, exact for 16-bit inputs.
    function automatic logic [12:0] seven_tenths(input logic [12:0] v);
        logic [15:0] x;
        logic [31:0] p;
        x = ({3'b000, v} << 3) - {3'b000, v};
        p = 32'(x) * 32'd52429;
        return 13'(p >> 19);
    endfunction

endpackage

/* rtl/crgs_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the seven sequencer settings; the core can also reload the step limit when walk mode ends.
// ----------------------------------------------------------------------------
module crgs_cfg
    import crgs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_data,
    input  logic                       i_step_reload,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_step_reload) begin
            n_cfg.step_limit = TURN_STEPS;
        end
        if (i_we) begin
            unique case (i_index)
                CFG_MOTOR_SPEED:  n_cfg.motor_speed  = i_data[12:0];
                CFG_TARGET_COUNT: n_cfg.target_count = i_data;
                CFG_STEP_LIMIT:   n_cfg.step_limit   = i_data[7:0];
                CFG_SETTLE_TICKS: n_cfg.settle_ticks = i_data;
                CFG_PRESS_TICKS:  n_cfg.press_ticks  = i_data;
                CFG_STEP_TICKS:   n_cfg.step_ticks   = i_data;
                CFG_SYNC_BAND:    n_cfg.sync_band    = i_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motor_speed  <= 13'd8000;
            r_cfg.target_count <= 16'd36;
            r_cfg.step_limit   <= 8'd9;
            r_cfg.settle_ticks <= 16'd1000;
            r_cfg.press_ticks  <= 16'd400;
            r_cfg.step_ticks   <= 16'd160;
            r_cfg.sync_band    <= 8'd2;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/crgs_core.sv */
// ----------------------------------------------------------------------------
// Gait sequencer core
// Mode state, actuator latches and the single-pass update for one item.
// ----------------------------------------------------------------------------
`include "climbing_robot_gait_sequencer_macros.svh"

module crgs_core
    import crgs_pkg::*;
#(
    parameter int TICK_WIDTH  = DEF_TICK_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result,
    output logic    o_step_reload
);

    localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};
    localparam logic [15:0] COUNT_MASK = (COUNT_WIDTH >= 16) ? 16'hFFFF :
        16'((32'd1 << COUNT_WIDTH) - 32'd1);

    logic [1:0]            r_mode, n_mode;
    logic [1:0]            r_hphase, n_hphase;
    logic [1:0]            r_pphase, n_pphase;
    logic                  r_wait, n_wait;
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic [7:0]            r_steps, n_steps;
    logic [1:0]            r_tdir, n_tdir;
    logic [7:0]            r_lastcmd, n_lastcmd;
    logic [12:0]           r_rpwm, n_rpwm;
    logic [12:0]           r_lpwm, n_lpwm;
    logic [3:0]            r_dir, n_dir;
    logic [5:0]            r_pads, n_pads;
    logic                  r_main, n_main;
    logic [8:0]            r_servo, n_servo;
    logic                  clr_r, clr_l, reload;

    logic [15:0] rc, lc;
    logic        any_sensor;
    logic [7:0]  turn_steps;
    logic [12:0] turn_pwm;
    logic [12:0] seven_in, seven_out;
    logic        rc_low, rc_high;

    assign rc = i_item.right_count & COUNT_MASK;
    assign lc = i_item.left_count & COUNT_MASK;
    assign any_sensor = i_item.right_sensor | i_item.left_sensor;

    // Turn mode counts a step on the rising edge of either sensor.
    assign turn_steps = (any_sensor && r_pphase == PHASE_0) ? r_steps + 8'd1 : r_steps;
    assign turn_pwm = TURN_BASE - 13'(13'(turn_steps[3:0]) * TURN_DROP);

    // One shared 7/10 unit: the turn ramp value in turn mode, the walk speed else.
    assign seven_in  = (r_mode == MODE_TURN) ? turn_pwm : i_cfg.motor_speed;
    assign seven_out = seven_tenths(seven_in);

    assign rc_low  = ({1'b0, rc} + {9'd0, i_cfg.sync_band}) < {1'b0, lc};
    assign rc_high = {1'b0, rc} > ({1'b0, lc} + {9'd0, i_cfg.sync_band});

    always_comb begin
        n_mode    = r_mode;
        n_hphase  = r_hphase;
        n_pphase  = r_pphase;
        n_wait    = r_wait;
        n_tick    = r_tick;
        n_steps   = r_steps;
        n_tdir    = r_tdir;
        n_lastcmd = r_lastcmd;
        n_rpwm    = r_rpwm;
        n_lpwm    = r_lpwm;
        n_dir     = r_dir;
        n_pads    = r_pads;
        n_main    = r_main;
        n_servo   = r_servo;
        clr_r     = 1'b0;
        clr_l     = 1'b0;
        reload    = 1'b0;

        if (i_item.operation == OP_TICK) begin
            if (r_tick != TICK_MAX) begin
                n_tick = r_tick + 1'b1;
            end
        end else if (i_item.operation == OP_CMD) begin
            n_lastcmd = i_item.command_byte;
            n_steps   = i_item.command_byte - CMD_OFFSET;
        end else if (i_item.operation == OP_PASS) begin
            unique case (r_mode)
                MODE_HOMING: begin
                    if (r_hphase == PHASE_0) begin
                        n_main = 1'b1;
                        n_lpwm = HOMING_PWM;
                        if (i_item.left_sensor) begin
                            n_hphase = PHASE_1;
                            n_lpwm   = 13'd0;
                            n_dir    = {DRV_BRAKE, r_dir[1:0]};
                            if (r_pphase == PHASE_0) begin
                                n_pphase = PHASE_1;
                                clr_l    = 1'b1;
                                n_rpwm   = HOMING_PWM;
                            end
                        end
                    end else if (r_hphase == PHASE_1) begin
                        if (i_item.right_sensor && r_pphase == PHASE_1) begin
                            n_pphase = PHASE_2;
                            clr_r    = 1'b1;
                            n_hphase = PHASE_2;
                        end
                    end else if (r_hphase == PHASE_2) begin
                        if (rc >= i_cfg.target_count) begin
                            if (!r_wait) begin
                                n_lpwm = 13'd0;
                                n_dir  = DIR_BRAKE;
                                n_tick = '0;
                                n_wait = 1'b1;
                            end
                            n_pads = PADS_ALL;
                            if (32'(n_tick) >= 32'(i_cfg.settle_ticks)) begin
                                n_servo  = SERVO_RELEASE;
                                n_hphase = PHASE_0;
                                clr_r    = 1'b1;
                                clr_l    = 1'b1;
                                n_pphase = PHASE_0;
                                n_wait   = 1'b0;
                                n_mode   = MODE_WALK;
                                n_main   = 1'b0;
                            end
                        end else begin
                            n_rpwm = HOMING_PWM;
                        end
                    end
                end
                MODE_WALK: begin
                    if (any_sensor && r_steps > i_cfg.step_limit) begin
                        // Leaving walk: press the servo, then switch after the press time.
                        n_main  = 1'b1;
                        n_servo = SERVO_PRESS;
                        if (32'(r_tick) >= 32'(i_cfg.press_ticks)) begin
                            n_steps = 8'd0;
                            n_mode  = (r_lastcmd == STOP_CMD) ? MODE_STOP : MODE_TURN;
                            n_pads  = PADS_NONE;
                            n_wait  = 1'b0;
                            if (r_tdir == 2'd0) begin
                                n_dir  = DIR_ROT_RIGHT;
                                n_tdir = 2'd1;
                                reload = 1'b1;
                            end else if (r_tdir == 2'd1) begin
                                n_dir  = DIR_ROT_LEFT;
                                n_tdir = 2'd2;
                                reload = 1'b1;
                            end
                        end
                    end else begin
                        if (any_sensor) begin
                            if (r_pphase == PHASE_0) begin
                                n_pphase = PHASE_1;
                                n_steps  = r_steps + 8'd1;
                                n_dir    = DIR_BRAKE;
                                n_pads   = PADS_ALL;
                                if (!r_wait) begin
                                    n_tick = '0;
                                    n_wait = 1'b1;
                                end
                            end
                            if (32'(n_tick) >= 32'(i_cfg.step_ticks)) begin
                                n_dir  = DIR_NORMAL;
                                n_pads = i_item.right_sensor ? PADS_LEFT_SET : PADS_RIGHT_SET;
                                n_wait = 1'b0;
                            end
                        end else begin
                            n_main   = 1'b0;
                            n_pphase = PHASE_0;
                        end
                        // Wheel sync: pause the wheel that runs ahead of the band.
                        if (rc_low) begin
                            n_rpwm = i_cfg.motor_speed;
                            n_lpwm = 13'd0;
                        end else if (rc_high) begin
                            n_rpwm = 13'd0;
                            n_lpwm = seven_out;
                        end else begin
                            n_rpwm = i_cfg.motor_speed;
                            n_lpwm = seven_out;
                        end
                    end
                end
                MODE_TURN: begin
                    n_steps  = turn_steps;
                    n_pphase = any_sensor ? PHASE_1 : PHASE_0;
                    if (turn_steps > TURN_STEPS) begin
                        n_steps  = 8'd0;
                        n_rpwm   = 13'd0;
                        n_pphase = PHASE_0;
                        n_dir    = DIR_NORMAL;
                        n_mode   = MODE_HOMING;
                    end else begin
                        n_rpwm = turn_pwm;
                        n_lpwm = seven_out;
                    end
                end
                MODE_STOP: begin
                    n_dir  = DIR_BRAKE;
                    n_pads = PADS_ALL;
                    n_main = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_HOMING;
            r_hphase  <= PHASE_0;
            r_pphase  <= PHASE_0;
            r_wait    <= 1'b0;
            r_tick    <= '0;
            r_steps   <= 8'd0;
            r_tdir    <= 2'd0;
            r_lastcmd <= 8'd0;
            r_rpwm    <= 13'd0;
            r_lpwm    <= 13'd0;
            r_dir     <= DIR_NORMAL;
            r_pads    <= PADS_NONE;
            r_main    <= 1'b1;
            r_servo   <= SERVO_PRESS;
        end else if (i_en) begin
            r_mode    <= n_mode;
            r_hphase  <= n_hphase;
            r_pphase  <= n_pphase;
            r_wait    <= n_wait;
            r_tick    <= n_tick;
            r_steps   <= n_steps;
            r_tdir    <= n_tdir;
            r_lastcmd <= n_lastcmd;
            r_rpwm    <= n_rpwm;
            r_lpwm    <= n_lpwm;
            r_dir     <= n_dir;
            r_pads    <= n_pads;
            r_main    <= n_main;
            r_servo   <= n_servo;
        end
    end

    always_comb begin
        o_result.right_pwm         = n_rpwm;
        o_result.left_pwm          = n_lpwm;
        o_result.right_direction   = n_dir[1:0];
        o_result.left_direction    = n_dir[3:2];
        o_result.pad_valves        = n_pads;
        o_result.main_valve        = n_main;
        o_result.servo_compare     = n_servo;
        o_result.clear_right_count = clr_r;
        o_result.clear_left_count  = clr_l;
        o_result.current_mode      = n_mode;
    end

    assign o_step_reload = i_en & reload;

    `CRGS_ASSERT_NEXT(a_tick_advance, i_clk, i_rst_n,
        i_en && i_item.operation == OP_TICK && r_tick != TICK_MAX,
        r_tick == TICK_WIDTH'($past(r_tick) + 1'b1), "tick counter did not advance")
    `CRGS_ASSERT_NEXT(a_walk_exit, i_clk, i_rst_n, r_mode == MODE_WALK,
        r_mode == MODE_WALK || r_mode == MODE_TURN || r_mode == MODE_STOP,
        "walk mode left toward homing")
    `CRGS_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !i_en,
        $stable(r_mode) && $stable(r_steps) && $stable(r_tick), "state moved without an item")
    `CRGS_ASSERT_SAME(a_strobe_pass, i_clk, i_rst_n, i_item.operation != OP_PASS,
        !clr_r && !clr_l, "encoder clear outside a control pass")

endmodule

/* rtl/climbing_robot_gait_sequencer.sv */
// Stages: input register, single-pass update, result register.
// Throughput: one transaction per cycle while the output side does not stall the input.
// The input side stalls only while both registers hold a transaction and the output is not ready.
// Reset (synchronous, active low) returns homing mode, default settings, empty stages.
// ----------------------------------------------------------------------------
// Climbing robot gait sequencer
// Streaming wrapper around the gait core with configuration registers.
// ----------------------------------------------------------------------------
module climbing_robot_gait_sequencer
    import crgs_pkg::*;
#(
    parameter int TICK_WIDTH  = DEF_TICK_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata from bit 0: right_sensor, left_sensor, right_count[15:0],
    // left_count[15:0], command_byte[7:0], zero fill
    input  logic [IN_DATA_WIDTH-1:0]   s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata from bit 0: right_pwm[12:0], left_pwm[12:0], right_direction[1:0],
    // left_direction[1:0], pad_valves[5:0], main_valve, servo_compare[8:0],
    // clear_right_count, clear_left_count, current_mode[1:0], zero fill
    output logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata
);

    t_cfg    cfg;
    t_item   r_item;
    t_result result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic [OUT_DATA_WIDTH-1:0] r_out_data;
    logic    advance;
    logic    core_en;
    logic    step_reload;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign core_en       = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.operation    <= s_axis_tuser;
            r_item.right_sensor <= s_axis_tdata[0];
            r_item.left_sensor  <= s_axis_tdata[1];
            r_item.right_count  <= s_axis_tdata[17:2];
            r_item.left_count   <= s_axis_tdata[33:18];
            r_item.command_byte <= s_axis_tdata[41:34];
        end
        if (core_en) begin
            r_out_data <= {6'd0, result.current_mode, result.clear_left_count,
                           result.clear_right_count, result.servo_compare,
                           result.main_valve, result.pad_valves, result.left_direction,
                           result.right_direction, result.left_pwm, result.right_pwm};
        end
    end

    crgs_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_we          (i_cfg_we),
        .i_index       (i_cfg_index),
        .i_data        (i_cfg_data),
        .i_step_reload (step_reload),
        .o_cfg         (cfg)
    );

    crgs_core #(
        .TICK_WIDTH  (TICK_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (core_en),
        .i_item        (r_item),
        .i_cfg         (cfg),
        .o_result      (result),
        .o_step_reload (step_reload)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* tb/tb_climbing_robot_gait_sequencer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gait sequencer testbench
// Drives control-pass, tick, command and unused transactions into the sequencer
// and compares every output transaction with a fixed value or an in-bench model
// of the homing, walk, turn and stop behavior, across several register settings.
// ----------------------------------------------------------------------------
module tb_climbing_robot_gait_sequencer;
    import crgs_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [2:0] CFG_NONE       = 3'd7;
    localparam logic [1:0] TURN_FIRST     = 2'd0;
    localparam logic [1:0] TURN_SECOND    = 2'd1;
    localparam logic [1:0] TURN_DONE      = 2'd2;
    localparam int         IDLE_PCT       = 12;
    localparam int         RX_HOLD_CYCLES = 60;
    localparam int         DRAIN_CYCLES   = 6;
    localparam int         PHASE_ITEMS    = 70;
    localparam int         STOP_SEEK_MAX  = 120;
    localparam int         MAX_REPORTS    = 200;
    localparam int         TIMEOUT_NS     = 5000000;

    // Register sets per phase, in register index order. Upper bits beyond the
    // register width are set in one phase to exercise masking.
    localparam logic [15:0] PHASE_REGS [5][7] = '{
        '{16'd8000, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd0,    16'd65535, 16'd3,     16'd5,     16'd3,     16'd2,     16'd255},
        '{16'hFF40, 16'd20,    16'hFF02,  16'd4,     16'd2,     16'd3,     16'hFF03},
        '{16'd4321, 16'd300,   16'd255,   16'd65535, 16'd65535, 16'd65535, 16'd1},
        '{16'd7999, 16'd5,     16'd1,     16'd1,     16'd1,     16'd1,     16'd2}
    };

    localparam t_result OUT_AT_RESET = '{13'd0, 13'd0, DIR_NORMAL[1:0], DIR_NORMAL[3:2],
        PADS_NONE, 1'b1, SERVO_PRESS, 1'b0, 1'b0, MODE_HOMING};
    localparam t_result OUT_LEFT_SEEK = '{13'd0, HOMING_PWM, DIR_NORMAL[1:0],
        DIR_NORMAL[3:2], PADS_NONE, 1'b1, SERVO_PRESS, 1'b0, 1'b0, MODE_HOMING};
    localparam t_result OUT_LEFT_HOME = '{HOMING_PWM, 13'd0, DIR_NORMAL[1:0], DRV_BRAKE,
        PADS_NONE, 1'b1, SERVO_PRESS, 1'b0, 1'b1, MODE_HOMING};

    typedef struct {
        bit          is_write;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        t_item       it;
        bit          typed;
        t_result     want;
    } t_stim_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]   s_axis_tdata;
    logic [1:0]                 s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata;

    climbing_robot_gait_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Model state of the sequencer.
    t_cfg        cfg_now;
    logic [1:0]  gait_mode;
    logic [1:0]  homing_step;
    logic [1:0]  edge_phase;
    logic [1:0]  turn_dir;
    logic        timer_armed;
    logic [15:0] tick_cnt;
    logic [7:0]  step_cnt;
    logic [7:0]  last_cmd;
    logic [12:0] rpwm;
    logic [12:0] lpwm;
    logic [3:0]  drive_dir;
    logic [5:0]  pad_set;
    logic        main_on;
    logic [8:0]  servo_pos;

    t_result pending_outputs [$];
    t_stim_row directed_rows [$];
    int  fail_count;
    bit  quiet;
    bit  rx_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [12:0] left_share(input logic [12:0] v);
        int unsigned p;
        p = int'(v) * 7;
        return 13'(p / 10);
    endfunction

    function automatic void reset_model();
        cfg_now.motor_speed  = 13'd8000;
        cfg_now.target_count = 16'd36;
        cfg_now.step_limit   = 8'd9;
        cfg_now.settle_ticks = 16'd1000;
        cfg_now.press_ticks  = 16'd400;
        cfg_now.step_ticks   = 16'd160;
        cfg_now.sync_band    = 8'd2;
        gait_mode   = MODE_HOMING;
        homing_step = PHASE_0;
        edge_phase  = PHASE_0;
        turn_dir    = TURN_FIRST;
        timer_armed = 1'b0;
        tick_cnt    = 16'd0;
        step_cnt    = 8'd0;
        last_cmd    = 8'd0;
        rpwm        = 13'd0;
        lpwm        = 13'd0;
        drive_dir   = DIR_NORMAL;
        pad_set     = PADS_NONE;
        main_on     = 1'b1;
        servo_pos   = SERVO_PRESS;
    endfunction

    function automatic void shadow_write(input logic [2:0] idx, input logic [15:0] d);
        case (idx)
            CFG_MOTOR_SPEED:  cfg_now.motor_speed  = d[12:0];
            CFG_TARGET_COUNT: cfg_now.target_count = d;
            CFG_STEP_LIMIT:   cfg_now.step_limit   = d[7:0];
            CFG_SETTLE_TICKS: cfg_now.settle_ticks = d;
            CFG_PRESS_TICKS:  cfg_now.press_ticks  = d;
            CFG_STEP_TICKS:   cfg_now.step_ticks   = d;
            CFG_SYNC_BAND:    cfg_now.sync_band    = d[7:0];
            default: ;
        endcase
    endfunction

    // Applies one accepted transaction to the model and returns the outputs it shows.
    function automatic t_result advance_gait(input t_item it);
        t_result res;
        logic    clr_r;
        logic    clr_l;
        logic    leaving;
        int      diff;
        int      band;
        int      v;
        clr_r   = 1'b0;
        clr_l   = 1'b0;
        leaving = 1'b0;
        case (it.operation)
            OP_TICK: begin
                if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
            end
            OP_CMD: begin
                last_cmd = it.command_byte;
                step_cnt = it.command_byte - CMD_OFFSET;
            end
            OP_PASS: begin
                case (gait_mode)
                    MODE_HOMING: begin
                        if (homing_step == PHASE_0) begin
                            main_on = 1'b1;
                            lpwm    = HOMING_PWM;
                            if (it.left_sensor) begin
                                homing_step    = PHASE_1;
                                lpwm           = 13'd0;
                                drive_dir[3:2] = DRV_BRAKE;
                                if (edge_phase == PHASE_0) begin
                                    edge_phase = PHASE_1;
                                    clr_l      = 1'b1;
                                    rpwm       = HOMING_PWM;
                                end
                            end
                        end else if (homing_step == PHASE_1) begin
                            if (it.right_sensor && edge_phase == PHASE_1) begin
                                edge_phase  = PHASE_2;
                                clr_r       = 1'b1;
                                homing_step = PHASE_2;
                            end
                        end else if (homing_step == PHASE_2) begin
                            if (it.right_count >= cfg_now.target_count) begin
                                if (!timer_armed) begin
                                    lpwm        = 13'd0;
                                    drive_dir   = DIR_BRAKE;
                                    tick_cnt    = 16'd0;
                                    timer_armed = 1'b1;
                                end
                                pad_set = PADS_ALL;
                                if (tick_cnt >= cfg_now.settle_ticks) begin
                                    servo_pos   = SERVO_RELEASE;
                                    homing_step = PHASE_0;
                                    clr_r       = 1'b1;
                                    clr_l       = 1'b1;
                                    edge_phase  = PHASE_0;
                                    timer_armed = 1'b0;
                                    gait_mode   = MODE_WALK;
                                    main_on     = 1'b0;
                                end
                            end else begin
                                rpwm = HOMING_PWM;
                            end
                        end
                    end
                    MODE_WALK: begin
                        if (it.right_sensor || it.left_sensor) begin
                            if (step_cnt > cfg_now.step_limit) begin
                                leaving   = 1'b1;
                                main_on   = 1'b1;
                                servo_pos = SERVO_PRESS;
                                if (tick_cnt >= cfg_now.press_ticks) begin
                                    step_cnt    = 8'd0;
                                    gait_mode   = (last_cmd == STOP_CMD) ? MODE_STOP : MODE_TURN;
                                    pad_set     = PADS_NONE;
                                    timer_armed = 1'b0;
                                    if (turn_dir == TURN_FIRST) begin
                                        drive_dir          = DIR_ROT_RIGHT;
                                        turn_dir           = TURN_SECOND;
                                        cfg_now.step_limit = TURN_STEPS;
                                    end else if (turn_dir == TURN_SECOND) begin
                                        drive_dir          = DIR_ROT_LEFT;
                                        turn_dir           = TURN_DONE;
                                        cfg_now.step_limit = TURN_STEPS;
                                    end
                                end
                            end else begin
                                if (edge_phase == PHASE_0) begin
                                    edge_phase = PHASE_1;
                                    step_cnt   = step_cnt + 8'd1;
                                    drive_dir  = DIR_BRAKE;
                                    pad_set    = PADS_ALL;
                                    if (!timer_armed) begin
                                        tick_cnt    = 16'd0;
                                        timer_armed = 1'b1;
                                    end
                                end
                                if (tick_cnt >= cfg_now.step_ticks) begin
                                    drive_dir   = DIR_NORMAL;
                                    pad_set     = it.right_sensor ? PADS_LEFT_SET : PADS_RIGHT_SET;
                                    timer_armed = 1'b0;
                                end
                            end
                        end else begin
                            main_on    = 1'b0;
                            edge_phase = PHASE_0;
                        end
                        // A pass that meets the walk exit condition does not touch the wheel speeds.
                        if (!leaving) begin
                            diff = int'(it.right_count) - int'(it.left_count);
                            band = int'(cfg_now.sync_band);
                            if (diff < -band) begin
                                rpwm = cfg_now.motor_speed;
                                lpwm = 13'd0;
                            end else if (diff > band) begin
                                rpwm = 13'd0;
                                lpwm = left_share(cfg_now.motor_speed);
                            end else begin
                                rpwm = cfg_now.motor_speed;
                                lpwm = left_share(cfg_now.motor_speed);
                            end
                        end
                    end
                    MODE_TURN: begin
                        if (it.right_sensor || it.left_sensor) begin
                            if (edge_phase == PHASE_0) begin
                                edge_phase = PHASE_1;
                                step_cnt   = step_cnt + 8'd1;
                            end
                        end else begin
                            edge_phase = PHASE_0;
                        end
                        if (step_cnt > TURN_STEPS) begin
                            step_cnt   = 8'd0;
                            rpwm       = 13'd0;
                            edge_phase = PHASE_0;
                            drive_dir  = DIR_NORMAL;
                            gait_mode  = MODE_HOMING;
                        end else begin
                            v    = int'(TURN_BASE) - int'(step_cnt) * int'(TURN_DROP);
                            rpwm = 13'(v);
                            lpwm = left_share(13'(v));
                        end
                    end
                    default: begin
                        drive_dir = DIR_BRAKE;
                        pad_set   = PADS_ALL;
                        main_on   = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
        res.right_pwm         = rpwm;
        res.left_pwm          = lpwm;
        res.right_direction   = drive_dir[1:0];
        res.left_direction    = drive_dir[3:2];
        res.pad_valves        = pad_set;
        res.main_valve        = main_on;
        res.servo_compare     = servo_pos;
        res.clear_right_count = clr_r;
        res.clear_left_count  = clr_l;
        res.current_mode      = gait_mode;
        return res;
    endfunction

    // Random transaction shaped by the current mode so that the gait gets past homing.
    function automatic t_item random_item(input bit allow_stop);
        t_item it;
        int    r;
        int    span;
        it.right_sensor = 1'($urandom_range(1));
        it.left_sensor  = 1'($urandom_range(1));
        it.right_count  = 16'($urandom);
        it.left_count   = 16'($urandom);
        it.command_byte = 8'($urandom);
        r = $urandom_range(99);
        if (r < 55)      it.operation = OP_PASS;
        else if (r < 85) it.operation = OP_TICK;
        else if (r < 96) it.operation = OP_CMD;
        else             it.operation = OP_UNUSED;
        if (gait_mode == MODE_HOMING && homing_step == PHASE_2 && $urandom_range(1) != 0)
            it.right_count = 16'($urandom_range(65535, int'(cfg_now.target_count)));
        if (gait_mode != MODE_HOMING && $urandom_range(9) < 4) begin
            it.right_sensor = 1'b0;
            it.left_sensor  = 1'b0;
        end
        if (gait_mode == MODE_WALK && $urandom_range(9) < 8) begin
            span = int'(cfg_now.sync_band) + 3;
            it.right_count = it.left_count + 16'($urandom_range(2 * span) - span);
        end
        if (it.operation == OP_CMD && $urandom_range(3) != 0)
            it.command_byte = CMD_OFFSET + 8'($urandom_range(int'(cfg_now.step_limit) + 2));
        if (it.command_byte == STOP_CMD && !allow_stop)
            it.command_byte = STOP_CMD + 8'd1;
        if (allow_stop && gait_mode == MODE_WALK && it.operation == OP_CMD &&
            $urandom_range(1) != 0)
            it.command_byte = STOP_CMD;
        return it;
    endfunction

    function automatic t_stim_row item_row(input logic [1:0] op, input logic rs,
                                           input logic ls, input logic [15:0] rc,
                                           input logic [15:0] lc, input logic [7:0] cb,
                                           input bit typed, input t_result want);
        t_stim_row row;
        row.is_write = 1'b0;
        row.reg_idx  = CFG_NONE;
        row.reg_val  = 16'd0;
        row.it       = '{op, rs, ls, rc, lc, cb};
        row.typed    = typed;
        row.want     = want;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic [2:0] idx, input logic [15:0] val);
        t_stim_row row;
        row          = item_row(OP_UNUSED, 1'b0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        return row;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned have);
        if (want != have) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, have);
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        shadow_write(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer_item(input t_item it, input bit typed, input t_result want);
        t_result pred;
        bit      taken;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.operation;
        s_axis_tdata  <= {6'd0, it.command_byte, it.left_count, it.right_count,
                          it.left_sensor, it.right_sensor};
        // Ready is sampled mid-cycle; the transaction completes at the next rising edge.
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        pred = advance_gait(it);
        pending_outputs.push_back(typed ? want : pred);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin : rx_side
        int n;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (n = 0; n < RX_HOLD_CYCLES; n++) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(negedge i_clk) begin : out_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outputs.size() == 0) begin
                fail_count++;
                $display("%0t ns: output transaction with none expected, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_outputs.pop_front();
                check_field("right_pwm", want.right_pwm, m_axis_tdata[12:0]);
                check_field("left_pwm", want.left_pwm, m_axis_tdata[25:13]);
                check_field("right_direction", want.right_direction, m_axis_tdata[27:26]);
                check_field("left_direction", want.left_direction, m_axis_tdata[29:28]);
                check_field("pad_valves", want.pad_valves, m_axis_tdata[35:30]);
                check_field("main_valve", want.main_valve, m_axis_tdata[36]);
                check_field("servo_compare", want.servo_compare, m_axis_tdata[45:37]);
                check_field("clear_right_count", want.clear_right_count, m_axis_tdata[46]);
                check_field("clear_left_count", want.clear_left_count, m_axis_tdata[47]);
                check_field("current_mode", want.current_mode, m_axis_tdata[49:48]);
            end
        end
    end

    initial begin : stimulus
        int    ph;
        int    k;
        int    cnt;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PASS;
        m_axis_tready = 1'b0;
        fail_count    = 0;
        quiet         = 1'b0;
        rx_hold_req   = 1'b0;
        reset_model();

        // Homing from reset, then a short walk, its exit into a turn and back.
        directed_rows.push_back(item_row(OP_UNUSED, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF,
                                         1'b1, OUT_AT_RESET));
        directed_rows.push_back(item_row(OP_TICK, 1'b0, 1'b0, 16'd0, 16'd0, 8'd0,
                                         1'b1, OUT_AT_RESET));
        directed_rows.push_back(item_row(OP_CMD, 1'b0, 1'b0, 16'd0, 16'd0, 8'd0,
                                         1'b1, OUT_AT_RESET));
        directed_rows.push_back(item_row(OP_CMD, 1'b0, 1'b0, 16'd0, 16'd0, 8'hFF,
                                         1'b1, OUT_AT_RESET));
        directed_rows.push_back(item_row(OP_CMD, 1'b0, 1'b0, 16'd0, 16'd0, STOP_CMD,
                                         1'b1, OUT_AT_RESET));
        directed_rows.push_back(item_row(OP_PASS, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 8'd0,
                                         1'b1, OUT_LEFT_SEEK));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b1, 16'd0, 16'd0, 8'd0,
                                         1'b1, OUT_LEFT_HOME));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b1, 16'd0, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b1, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b0, 16'd35, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b0, 16'd36, 16'd0, 8'd0, 1'b0, '0));
        for (k = 0; k < 3; k++)
            directed_rows.push_back(item_row(OP_TICK, 1'b1, 1'b1, 16'd0, 16'd0, 8'd0,
                                             1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b0, 16'hFFFF, 16'd0, 8'd0,
                                         1'b0, '0));
        directed_rows.push_back(item_row(OP_CMD, 1'b0, 1'b0, 16'd0, 16'd0, CMD_OFFSET,
                                         1'b0, '0));
        directed_rows.push_back(reg_row(CFG_SETTLE_TICKS, 16'd3));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b0, 16'd40, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(reg_row(CFG_STEP_LIMIT, 16'd0));
        directed_rows.push_back(reg_row(CFG_PRESS_TICKS, 16'd1));
        directed_rows.push_back(reg_row(CFG_STEP_TICKS, 16'd0));
        directed_rows.push_back(item_row(OP_PASS, 1'b1, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b0, 16'd0, 16'd10, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b1, 16'd10, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_TICK, 1'b0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b1, 16'd10, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b1, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0, '0));
        directed_rows.push_back(item_row(OP_CMD, 1'b0, 1'b0, 16'd0, 16'd0,
                                         CMD_OFFSET + 8'd10, 1'b0, '0));
        directed_rows.push_back(item_row(OP_PASS, 1'b0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_write) begin
                drain_outputs();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                offer_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].want);
            end
        end

        for (ph = 0; ph < 5; ph++) begin
            drain_outputs();
            quiet = 1'b0;
            for (k = 0; k < 7; k++) write_reg(3'(k), PHASE_REGS[ph][k]);
            if (ph == 2) begin
                write_reg(CFG_NONE, 16'hFFFF);
                quiet = 1'b1;
            end
            // The output side stalls for a long stretch while transactions keep coming.
            if (ph == 0) rx_hold_req = 1'b1;
            cnt = 0;
            while (cnt < PHASE_ITEMS ||
                   (ph == 4 && gait_mode != MODE_STOP && cnt < STOP_SEEK_MAX)) begin
                offer_item(random_item(ph == 4), 1'b0, '0);
                cnt++;
            end
        end
        for (k = 0; k < 20; k++) offer_item(random_item(1'b1), 1'b0, '0);

        drain_outputs();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
